### design/koet_pkg.sv
// ----------------------------------------------------------------------------
// koet_pkg: shared types and constants for the keyed ordered entry table
// Holds capacity, status and operation codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package koet_pkg;

  localparam int Capacity     = 16;
  localparam int PayloadBytes = 8;
  localparam int SlotW        = $clog2(Capacity);
  localparam int CountW       = $clog2(Capacity + 1);

  typedef logic [SlotW-1:0] slot_t;

  typedef enum logic [2:0] {
    OP_INSERT    = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_FIND      = 3'd2,
    OP_FIND_NEXT = 3'd3,
    OP_FIND_PREV = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_FULL         = 3'd1,
    ST_DUP          = 3'd2,
    ST_MISSING      = 3'd3,
    ST_NO_NEIGHBOUR = 3'd4
  } status_t;

  localparam logic REG_MAX_ENTRIES = 1'b0;
  localparam logic REG_DATA_BYTES  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_DECIDE,
    S_LINK,
    S_NBR,
    S_DONE
  } state_t;

  // Write request into the slot memory, with a write enable per field group.
  typedef struct packed {
    logic  key_we;
    logic  pay_we;
    logic  next_we;
    logic  prev_we;
    slot_t addr;
    logic [15:0] key;
    logic [63:0] pay;
    slot_t link;
  } mem_wr_t;

  typedef struct packed {
    logic [15:0] key;
    logic [63:0] pay;
    slot_t       next;
    slot_t       prev;
  } mem_rd_t;

endpackage

### design/koet_slot_mem.sv
// ----------------------------------------------------------------------------
// koet_slot_mem: slot storage for keys, payloads and links
// Synchronous memory, one write and one read port, read data registered.
// ----------------------------------------------------------------------------
module koet_slot_mem (
  input  logic               clk,
  input  koet_pkg::mem_wr_t  wr,
  input  koet_pkg::slot_t    raddr,
  output koet_pkg::mem_rd_t  rd
);

  logic [15:0]     key_mem  [koet_pkg::Capacity];
  logic [63:0]     pay_mem  [koet_pkg::Capacity];
  koet_pkg::slot_t next_mem [koet_pkg::Capacity];
  koet_pkg::slot_t prev_mem [koet_pkg::Capacity];

  always_ff @(posedge clk) begin
    if (wr.key_we)  key_mem[wr.addr]  <= wr.key;
    if (wr.pay_we)  pay_mem[wr.addr]  <= wr.pay;
    if (wr.next_we) next_mem[wr.addr] <= wr.link;
    if (wr.prev_we) prev_mem[wr.addr] <= wr.link;
    rd.key  <= key_mem[raddr];
    rd.pay  <= pay_mem[raddr];
    rd.next <= next_mem[raddr];
    rd.prev <= prev_mem[raddr];
  end

endmodule

### design/keyed_ordered_entry_table.sv
// ----------------------------------------------------------------------------
// keyed_ordered_entry_table: insertion-ordered keyed table
// Doubly linked list over a fixed slot memory with a scanning sequencer.
// ----------------------------------------------------------------------------
// Each start transfer runs one operation to completion; busy stays high until
// the result strobe. The key search reads all slots, one slot per cycle, from
// the slot memory (registered read data); a decide step follows, and done is
// strobed in the last busy cycle. Insert and removal of a middle entry add
// link-update writes before done; a find, find-next or find-prev adds a
// payload read. The next start is taken in the cycle after done. Unknown
// operations skip the scan and strobe done in the cycle after the transfer.
// The result is shown for exactly one cycle with done high; the receiver
// cannot stall it. Configuration writes take effect at once; issue them only
// while no operation is in progress.
module keyed_ordered_entry_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [15:0] key,
  input  logic [63:0] payload,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [63:0] data_out,
  output logic [4:0]  entry_count
);

  localparam int SW = koet_pkg::SlotW;
  localparam int CW = koet_pkg::CountW;

  koet_pkg::state_t  state, state_next;
  koet_pkg::mem_wr_t wr;
  koet_pkg::mem_rd_t rd;
  koet_pkg::slot_t   raddr;

  // Held operation.
  logic [2:0]  op;
  logic [15:0] op_key;
  logic [63:0] op_pay;

  // Control state.
  logic [koet_pkg::Capacity-1:0] used;
  koet_pkg::slot_t head, tail;
  logic [CW-1:0]   total;
  logic [4:0]      max_entries;
  logic [3:0]      data_bytes;

  // Scan bookkeeping.
  logic [SW:0]     scan;
  koet_pkg::slot_t rd_slot;
  logic            rd_valid;
  logic            hit;
  koet_pkg::slot_t hit_slot;
  koet_pkg::slot_t hit_next, hit_prev;

  // Old tail, captured before the insert moves the tail pointer.
  koet_pkg::slot_t hit_prev_tail;

  // Link-update pass: step through up to two link writes.
  logic [1:0]      step;
  logic [2:0]      res_status;
  logic [63:0]     res_data;

  koet_slot_mem u_mem (
    .clk  (clk),
    .wr   (wr),
    .raddr(raddr),
    .rd   (rd)
  );

  // Free slot: lowest unused.
  koet_pkg::slot_t free_slot;
  logic            free_any;
  always_comb begin
    free_slot = '0;
    free_any  = 1'b0;
    for (int i = koet_pkg::Capacity - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_slot = SW'(i);
        free_any  = 1'b1;
      end
    end
  end

  logic [CW-1:0] limit;
  assign limit = (max_entries > 5'(koet_pkg::Capacity)) ? CW'(koet_pkg::Capacity)
                                                       : CW'(max_entries);

  logic [63:0] pay_mask;
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      pay_mask[8*b +: 8] = ((b < koet_pkg::PayloadBytes) && (4'(b) < data_bytes))
                           ? 8'hFF : 8'h00;
    end
  end

  logic is_head, is_tail;
  assign is_head = (hit_slot == head);
  assign is_tail = (hit_slot == tail);

  // Insert goes ahead only with room under the limit and no matching key.
  logic insert_ok;
  assign insert_ok = (op == koet_pkg::OP_INSERT) && !(total >= limit || !free_any) && !hit;

  // Status of the held operation once the scan is over.
  logic [2:0] dec_status;
  always_comb begin
    dec_status = koet_pkg::ST_OK;
    if (op == koet_pkg::OP_INSERT) begin
      if (total >= limit || !free_any) begin
        dec_status = koet_pkg::ST_FULL;
      end else if (hit) begin
        dec_status = koet_pkg::ST_DUP;
      end
    end else if (op == koet_pkg::OP_REMOVE || op == koet_pkg::OP_FIND ||
                 op == koet_pkg::OP_FIND_NEXT || op == koet_pkg::OP_FIND_PREV) begin
      if (!hit) begin
        dec_status = koet_pkg::ST_MISSING;
      end else if (op == koet_pkg::OP_FIND_NEXT && is_tail) begin
        dec_status = koet_pkg::ST_NO_NEIGHBOUR;
      end else if (op == koet_pkg::OP_FIND_PREV && is_head) begin
        dec_status = koet_pkg::ST_NO_NEIGHBOUR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= koet_pkg::S_IDLE;
      used        <= '0;
      head        <= '0;
      tail        <= '0;
      total       <= '0;
      max_entries <= 5'd16;
      data_bytes  <= 4'd8;
      rd_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          koet_pkg::REG_MAX_ENTRIES: max_entries <= cfg_data;
          koet_pkg::REG_DATA_BYTES:  data_bytes  <= cfg_data[3:0];
          default: ;
        endcase
      end
      // Track whether the memory read data belongs to a scan read.
      rd_valid <= (state == koet_pkg::S_SCAN) && used[scan[SW-1:0]];
      unique case (state)
        koet_pkg::S_IDLE: begin
          if (start) begin
            op     <= operation;
            op_key <= key;
            op_pay <= payload;
            scan   <= '0;
            hit    <= 1'b0;
            step   <= '0;
          end
        end
        koet_pkg::S_SCAN: begin
          rd_slot <= scan[SW-1:0];
          scan    <= scan + 1'b1;
        end
        koet_pkg::S_SCAN_WAIT: ;
        koet_pkg::S_DECIDE: begin
          res_status <= dec_status;
          res_data   <= '0;
          if (insert_ok) begin
            used[free_slot] <= 1'b1;
            if (total == '0) head <= free_slot;
            tail     <= free_slot;
            total    <= total + 1'b1;
            hit_slot <= free_slot;
          end else if (op == koet_pkg::OP_REMOVE && hit) begin
            if (is_head && is_tail) begin
              head <= '0;
              tail <= '0;
            end else if (is_head) begin
              head <= hit_next;
            end else if (is_tail) begin
              tail <= hit_prev;
            end
            used[hit_slot] <= 1'b0;
            total <= total - 1'b1;
          end
        end
        koet_pkg::S_LINK: step <= step + 1'b1;
        koet_pkg::S_NBR: if (res_status == koet_pkg::ST_OK) res_data <= rd.pay;
        koet_pkg::S_DONE: ;
        default: ;
      endcase
      if (state == koet_pkg::S_IDLE && start &&
          !(operation == koet_pkg::OP_INSERT || operation == koet_pkg::OP_REMOVE ||
            operation == koet_pkg::OP_FIND || operation == koet_pkg::OP_FIND_NEXT ||
            operation == koet_pkg::OP_FIND_PREV)) begin
        res_status <= koet_pkg::ST_OK;
        res_data   <= '0;
      end
      // Capture a scan hit.
      if (rd_valid && !hit && rd.key == op_key) begin
        hit      <= 1'b1;
        hit_slot <= rd_slot;
        hit_next <= rd.next;
        hit_prev <= rd.prev;
      end
    end
  end

  logic valid_op;
  assign valid_op = (operation == koet_pkg::OP_INSERT) || (operation == koet_pkg::OP_REMOVE) ||
                    (operation == koet_pkg::OP_FIND) || (operation == koet_pkg::OP_FIND_NEXT) ||
                    (operation == koet_pkg::OP_FIND_PREV);

  // Which memory writes and reads the sequencer issues.
  logic remove_mid;
  assign remove_mid = (op == koet_pkg::OP_REMOVE) && hit && !is_head && !is_tail;

  always_comb begin
    state_next = state;
    wr         = '0;
    raddr      = scan[SW-1:0];
    busy       = (state != koet_pkg::S_IDLE);
    done       = (state == koet_pkg::S_DONE);
    unique case (state)
      koet_pkg::S_IDLE: begin
        if (start) state_next = valid_op ? koet_pkg::S_SCAN : koet_pkg::S_DONE;
      end
      koet_pkg::S_SCAN: begin
        raddr = scan[SW-1:0];
        if (scan == (SW+1)'(koet_pkg::Capacity - 1)) state_next = koet_pkg::S_SCAN_WAIT;
      end
      koet_pkg::S_SCAN_WAIT: state_next = koet_pkg::S_DECIDE;
      koet_pkg::S_DECIDE: begin
        // The insert writes the new entry here; links follow.
        // A find reads its payload here and takes it in the next cycle.
        if (insert_ok) begin
          wr.key_we  = 1'b1;
          wr.pay_we  = 1'b1;
          wr.next_we = 1'b1;
          wr.addr    = free_slot;
          wr.key     = op_key;
          wr.pay     = op_pay & pay_mask;
          wr.link    = '0;
          state_next = koet_pkg::S_LINK;
        end else if (remove_mid) begin
          state_next = koet_pkg::S_LINK;
        end else if (hit && op == koet_pkg::OP_FIND) begin
          raddr      = hit_slot;
          state_next = koet_pkg::S_NBR;
        end else if (hit && op == koet_pkg::OP_FIND_NEXT && !is_tail) begin
          raddr      = hit_next;
          state_next = koet_pkg::S_NBR;
        end else if (hit && op == koet_pkg::OP_FIND_PREV && !is_head) begin
          raddr      = hit_prev;
          state_next = koet_pkg::S_NBR;
        end else begin
          state_next = koet_pkg::S_DONE;
        end
      end
      koet_pkg::S_LINK: begin
        // Insert: prev of new entry, then next of old tail.
        // Remove: next of predecessor, then prev of successor.
        if (op == koet_pkg::OP_INSERT) begin
          if (step == 2'd0) begin
            wr.prev_we = 1'b1;
            wr.addr    = hit_slot;
            wr.link    = (total == CW'(1)) ? '0 : hit_prev_tail;
          end else begin
            wr.next_we = (total != CW'(1));
            wr.addr    = hit_prev_tail;
            wr.link    = hit_slot;
          end
        end else begin
          if (step == 2'd0) begin
            wr.next_we = 1'b1;
            wr.addr    = hit_prev;
            wr.link    = hit_next;
          end else begin
            wr.prev_we = 1'b1;
            wr.addr    = hit_next;
            wr.link    = hit_prev;
          end
        end
        if (step == 2'd1) state_next = koet_pkg::S_DONE;
      end
      koet_pkg::S_NBR: state_next = koet_pkg::S_DONE;
      koet_pkg::S_DONE: state_next = koet_pkg::S_IDLE;
      default: state_next = koet_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == koet_pkg::S_DECIDE) hit_prev_tail <= tail;
  end

  assign status      = res_status;
  assign data_out    = res_data;
  assign entry_count = 5'(total);

endmodule

### design/keyed_ordered_entry_table_checker.sv
// ----------------------------------------------------------------------------
// keyed_ordered_entry_table_checker: port-level checks
// Watches the command handshake and result counts at the top-level ports.
// ----------------------------------------------------------------------------
module keyed_ordered_entry_table_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic [63:0] data_out,
  input logic [4:0]  entry_count
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy did not rise after start");

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held over two cycles");

  a_data_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    done && status != koet_pkg::ST_OK |-> data_out == 64'd0) else $error("data on error");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> entry_count <= 5'd16) else $error("entry count out of range");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    done && $past(done, 1) == 1'b0 && !$stable(entry_count) |->
      (status == koet_pkg::ST_OK)) else $error("count changed on a refused operation");

endmodule

bind keyed_ordered_entry_table keyed_ordered_entry_table_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .data_out(data_out), .entry_count(entry_count)
);
